### hw/rtl/pmt_pkg.sv
// Package for the prescaled match timer.
// Holds field widths, function and register codes, and the shared structs.
// No dependencies.
package pmt_pkg;

    localparam int COUNT_W = 32;
    localparam int FLAG_W = 4;
    localparam int MAX_CHANNELS = 4;
    localparam int MATCH_CHANNELS_DEF = 4;
    localparam int CTL_BITS = 3;
    localparam int CTL_W = CTL_BITS * MAX_CHANNELS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int CTL_IRQ = 0;
    localparam int CTL_RESET = 1;
    localparam int CTL_STOP = 2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_CTRL  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESCALE = 3'd0,
        REG_MATCH0   = 3'd1,
        REG_MATCH1   = 3'd2,
        REG_MATCH2   = 3'd3,
        REG_MATCH3   = 3'd4,
        REG_CONTROL  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0]                   prescale_limit;
        logic [MAX_CHANNELS-1:0][COUNT_W-1:0] cmp_value;
        logic [CTL_W-1:0]                     match_control;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        func;
        logic              enable_bit;
        logic              hold_reset;
        logic [FLAG_W-1:0] clear_mask;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_value;
        logic [FLAG_W-1:0]  match_flags;
        logic               irq_line;
        logic               running;
    } res_t;

endpackage

### hw/rtl/prescaled_match_timer_top.sv
// Top level of the prescaled match timer: request register, result register.
// Instantiates pmt_cfg_regs and pmt_core; depends on pmt_pkg.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    func, enable_bit, hold_reset, clear_mask
//   m_       out        m_valid/m_ready    count_value, match_flags, irq_line, running
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// A request is held in the request register and then moves into the result
// register, which raises m_valid; one request is taken every cycle unless the
// output stalls. Reset is synchronous and active low and clears the valid flags,
// core state and config registers, but not the request and result data.
// A stalled result holds the request register; s_ready drops only when both
// registers are full and m_ready is low.
module prescaled_match_timer_top #(
    parameter int MATCH_CHANNELS = pmt_pkg::MATCH_CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic                           s_enable_bit,
    input  logic                           s_hold_reset,
    input  logic [pmt_pkg::FLAG_W-1:0]     s_clear_mask,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pmt_pkg::COUNT_W-1:0]    m_count_value,
    output logic [pmt_pkg::FLAG_W-1:0]     m_match_flags,
    output logic                           m_irq_line,
    output logic                           m_running,
    input  logic                           cfg_wr_en,
    input  logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmt_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    pmt_pkg::cfg_t cfg;
    pmt_pkg::req_t req_reg;
    pmt_pkg::res_t res_reg, res_next;
    logic          req_valid_reg;
    logic          res_valid_reg;
    logic          step;

    assign step    = req_valid_reg & (~res_valid_reg | m_ready);
    assign s_ready = ~req_valid_reg | ~res_valid_reg | m_ready;

    pmt_cfg_regs #(.MATCH_CHANNELS(MATCH_CHANNELS)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pmt_core #(.MATCH_CHANNELS(MATCH_CHANNELS)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                req_valid_reg <= 1'b1;
            end else if (step) begin
                req_valid_reg <= 1'b0;
            end
            if (step) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.func       <= s_func;
            req_reg.enable_bit <= s_enable_bit;
            req_reg.hold_reset <= s_hold_reset;
            req_reg.clear_mask <= s_clear_mask;
        end
        if (step) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_count_value = res_reg.count_value;
    assign m_match_flags = res_reg.match_flags;
    assign m_irq_line    = res_reg.irq_line;
    assign m_running     = res_reg.running;

endmodule

### hw/rtl/pmt_cfg_regs.sv
// Configuration register file of the prescaled match timer.
// Decodes plain register writes into a cfg_t; depends on pmt_pkg.
module pmt_cfg_regs #(
    parameter int MATCH_CHANNELS = pmt_pkg::MATCH_CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pmt_pkg::cfg_t                  cfg
);

    logic [pmt_pkg::COUNT_W-1:0]                     prescale_reg;
    logic [MATCH_CHANNELS-1:0][pmt_pkg::COUNT_W-1:0] match_reg;
    logic [pmt_pkg::CTL_W-1:0]                       control_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            match_reg    <= '0;
            control_reg  <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == pmt_pkg::REG_PRESCALE) begin
                prescale_reg <= cfg_wdata[pmt_pkg::COUNT_W-1:0];
            end
            for (int n = 0; n < MATCH_CHANNELS; n++) begin
                if (cfg_index == pmt_pkg::CFG_IDX_W'(int'(pmt_pkg::REG_MATCH0) + n)) begin
                    match_reg[n] <= cfg_wdata[pmt_pkg::COUNT_W-1:0];
                end
            end
            if (cfg_index == pmt_pkg::REG_CONTROL) begin
                control_reg <= cfg_wdata[pmt_pkg::CTL_W-1:0];
            end
        end
    end

    always_comb begin
        cfg.prescale_limit = prescale_reg;
        cfg.match_control  = control_reg;
        cfg.cmp_value      = '0;
        for (int n = 0; n < MATCH_CHANNELS; n++) begin
            cfg.cmp_value[n] = match_reg[n];
        end
    end

endmodule

### hw/rtl/pmt_core.sv
// Timer state and per-request update logic of the prescaled match timer.
// Holds prescaler, count, flags and control state; depends on pmt_pkg.
module pmt_core #(
    parameter int MATCH_CHANNELS = pmt_pkg::MATCH_CHANNELS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  pmt_pkg::req_t req,
    input  pmt_pkg::cfg_t cfg,
    output pmt_pkg::res_t res
);

    logic [pmt_pkg::COUNT_W-1:0] tick_reg, tick_next;
    logic [pmt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [MATCH_CHANNELS-1:0]   pending_reg, pending_next;
    logic                        enabled_reg, enabled_next;
    logic                        held_reg, held_next;

    logic [MATCH_CHANNELS-1:0]   hit_irq;
    logic                        do_reset;
    logic                        do_stop;
    logic [pmt_pkg::CTL_BITS-1:0] ctl;
    logic [pmt_pkg::FLAG_W-1:0]  flags_out;

    always_comb begin
        hit_irq  = '0;
        do_reset = 1'b0;
        do_stop  = 1'b0;
        ctl      = '0;
        for (int n = 0; n < MATCH_CHANNELS; n++) begin
            ctl = cfg.match_control[pmt_pkg::CTL_BITS*n +: pmt_pkg::CTL_BITS];
            if (count_reg == cfg.cmp_value[n]) begin
                hit_irq[n] = ctl[pmt_pkg::CTL_IRQ];
                do_reset   = do_reset | ctl[pmt_pkg::CTL_RESET];
                do_stop    = do_stop | ctl[pmt_pkg::CTL_STOP];
            end
        end
    end

    always_comb begin
        tick_next    = tick_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        enabled_next = enabled_reg;
        held_next    = held_reg;
        case (req.func)
            pmt_pkg::FUNC_TICK: begin
                if (held_reg) begin
                    tick_next  = '0;
                    count_next = '0;
                end else if (enabled_reg) begin
                    if (tick_reg == cfg.prescale_limit) begin
                        tick_next    = '0;
                        pending_next = pending_reg | hit_irq;
                        if (do_reset) begin
                            count_next = '0;
                        end else if (!do_stop) begin
                            count_next = count_reg + 1'b1;
                        end
                        if (do_stop) begin
                            enabled_next = 1'b0;
                        end
                    end else begin
                        tick_next = tick_reg + 1'b1;
                    end
                end
            end
            pmt_pkg::FUNC_CTRL: begin
                enabled_next = req.enable_bit;
                held_next    = req.hold_reset;
                if (req.hold_reset) begin
                    tick_next  = '0;
                    count_next = '0;
                end
            end
            pmt_pkg::FUNC_CLEAR: begin
                for (int n = 0; n < MATCH_CHANNELS; n++) begin
                    pending_next[n] = pending_reg[n] & ~req.clear_mask[n];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
            enabled_reg <= 1'b0;
            held_reg    <= 1'b0;
        end else if (step) begin
            tick_reg    <= tick_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            enabled_reg <= enabled_next;
            held_reg    <= held_next;
        end
    end

    always_comb begin
        flags_out = '0;
        for (int n = 0; n < MATCH_CHANNELS; n++) begin
            flags_out[n] = pending_next[n];
        end
        res.count_value = count_next;
        res.match_flags = flags_out;
        res.irq_line    = |flags_out;
        res.running     = enabled_next & ~held_next;
    end

endmodule

### hw/rtl/pmt_checker.sv
// Port-level checker for the prescaled match timer, bound to the top level.
// Depends on pmt_pkg and prescaled_match_timer_top.
module pmt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pmt_pkg::COUNT_W-1:0] m_count_value,
    input logic [pmt_pkg::FLAG_W-1:0]  m_match_flags,
    input logic                        m_irq_line
);

    // The interrupt line must agree with the flags it reports.
    a_irq_matches_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_irq_line == (m_match_flags != '0)))
        else $error("irq_line disagrees with match_flags");

    // Requests are refused only while a finished result waits to be taken.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without an output stall");

    // Reset leaves no result pending.
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_count_value)
                                   && $stable(m_match_flags)))
        else $error("stalled result changed");

endmodule

bind prescaled_match_timer_top pmt_checker u_pmt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_count_value (m_count_value),
    .m_match_flags (m_match_flags),
    .m_irq_line    (m_irq_line)
);
